// ===== hdl/slq_pkg.sv =====
`timescale 1ns / 1ps

package slq_pkg;

    // fixed field widths
    localparam int SEQ_W  = 30;
    localparam int CHK_W  = 16;
    localparam int STAT_W = 3;
    localparam int CIDX_W = 1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd0;
    localparam logic [STAT_W-1:0] ST_FIRST        = 3'd1;
    localparam logic [STAT_W-1:0] ST_RECOVERED    = 3'd2;
    localparam logic [STAT_W-1:0] ST_IN_ORDER     = 3'd3;
    localparam logic [STAT_W-1:0] ST_GAP          = 3'd4;
    localparam logic [STAT_W-1:0] ST_BACKWARD     = 3'd5;

    // config register indexes
    localparam logic [CIDX_W-1:0] REG_SEQ_RANGE   = 1'd0;
    localparam logic [CIDX_W-1:0] REG_CHECK_DEPTH = 1'd1;

    // per-cycle command to the list cells
    typedef struct packed {
        logic             shift;  // every cell not being loaded takes its right neighbor
        logic             load;   // the addressed cell takes val
        logic [SEQ_W-1:0] val;
    } cell_ctl_t;

endpackage

// ===== hdl/slq_cell.sv =====
`timescale 1ns / 1ps

// One entry of the missing-number list
module slq_cell #(
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  slq_pkg::cell_ctl_t       ctl,
    input  logic [IW-1:0]            load_pos,
    input  logic [slq_pkg::SEQ_W-1:0] right_in,
    output logic [slq_pkg::SEQ_W-1:0] value
);
    import slq_pkg::*;

    logic [SEQ_W-1:0] value_reg;
    logic [SEQ_W-1:0] value_next;
    logic             hit;

    assign hit = ctl.load && (load_pos == IW'(IDX));

    // load wins over shift so a rotated head lands at the tail
    always_comb
    begin
        value_next = value_reg;
        if (hit)
        begin
            value_next = ctl.val;
        end
        else if (ctl.shift)
        begin
            value_next = right_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== hdl/sequence_gap_loss_tracker_top.sv =====
`timescale 1ns / 1ps

// Sequence gap and loss tracker.
// Input: pulse start with seq_number while busy is low; the word is taken at
// that edge. Result: done is high for exactly one cycle with status,
// previous_seq, gap_added, alarm_valid, alarm_seq and list_overflow valid;
// the receiver cannot stall, so nothing is held back.
// Config: cfg_we with cfg_index/cfg_wdata writes seq_range (0) or
// check_depth (1); write only while busy is low.
// Timing: one item at a time; done is registered and comes once the FSM is
// back in idle, where busy is already low, so the next word can be taken
// while done is high. Out-of-range and first words end after the pre-check.
// Other words rotate the list once through the cell chain to search it (an
// empty list skips the search); a recovered word ends there. Otherwise the
// loss check and classification follow; on a gap the missing numbers are
// appended one entry per cycle, in two runs when the gap wraps, and a full
// list ends the fill.
// Reset: list empty, next item is taken as the first, seq_range = 10000,
// check_depth = 16. done is low after reset.
module sequence_gap_loss_tracker_top #(
    parameter int LOST_DEPTH = 256,
    parameter int SEQ_WIDTH  = 30
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [slq_pkg::SEQ_W-1:0]  seq_number,
    input  logic                       cfg_we,
    input  logic [slq_pkg::CIDX_W-1:0] cfg_index,
    input  logic [slq_pkg::SEQ_W-1:0]  cfg_wdata,
    output logic                       done,
    output logic [slq_pkg::STAT_W-1:0] status,
    output logic [slq_pkg::SEQ_W-1:0]  previous_seq,
    output logic [slq_pkg::SEQ_W-1:0]  gap_added,
    output logic                       alarm_valid,
    output logic [slq_pkg::SEQ_W-1:0]  alarm_seq,
    output logic                       list_overflow
);
    import slq_pkg::*;

    localparam int CW  = $clog2(LOST_DEPTH + 1);
    localparam int IW  = $clog2(LOST_DEPTH);
    localparam int W1  = SEQ_W + 1;
    localparam int SWE = (SEQ_WIDTH < SEQ_W) ? SEQ_WIDTH : SEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_W'((64'd1 << SWE) - 64'd1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PRE    = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_ALARM  = 7'b0001000,
        S_CLASS  = 7'b0010000,
        S_APPEND = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SEQ_W-1:0] range_reg;
    logic [CHK_W-1:0] check_reg;
    logic [SEQ_W-1:0] last_reg;
    logic             first_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    scan_reg;
    logic             found_reg;
    logic             wrap_reg;
    logic [SEQ_W-1:0] n_reg;
    logic [W1-1:0]    lo_reg;
    logic [W1-1:0]    hi_reg;
    logic             done_reg;

    logic [STAT_W-1:0] status_reg;
    logic [SEQ_W-1:0]  prev_reg;
    logic [SEQ_W-1:0]  added_reg;
    logic              alarm_v_reg;
    logic [SEQ_W-1:0]  alarm_s_reg;
    logic              over_reg;

    cell_ctl_t        ctl;
    logic [IW-1:0]    load_pos;
    logic [SEQ_W-1:0] cell_val [LOST_DEPTH];
    logic [SEQ_W-1:0] head;

    // cell chain, entry 0 is the oldest
    genvar gi;
    generate
        for (gi = 0; gi < LOST_DEPTH; gi++)
        begin : g_cell
            logic [SEQ_W-1:0] right;
            if (gi == LOST_DEPTH - 1)
            begin : g_end
                assign right = cell_val[gi];
            end
            else
            begin : g_mid
                assign right = cell_val[gi+1];
            end
            slq_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .load_pos (load_pos),
                .right_in (right),
                .value    (cell_val[gi])
            );
        end
    endgenerate

    assign head = cell_val[0];

    // comparisons, all in 31-bit unsigned
    logic [W1-1:0] n1, l1, r1, h1, half1, c1;
    logic head_match, list_full, run_left, alarm_hit;
    logic in_order, fwd_gap, wrap_gap, out_range;

    always_comb
    begin
        n1    = {1'b0, n_reg};
        l1    = {1'b0, last_reg};
        r1    = {1'b0, range_reg};
        h1    = {1'b0, head};
        half1 = r1 >> 1;
        c1    = W1'(check_reg);
        out_range  = n1 >= r1;
        head_match = !found_reg && (head == n_reg);
        list_full  = count_reg == CW'(LOST_DEPTH);
        run_left   = lo_reg < hi_reg;
        alarm_hit  = (count_reg != '0) &&
                     (((n1 < h1 + half1) && (n1 >= h1 + c1)) ||
                      ((n1 + half1 < h1) && (n1 + r1 >= h1 + c1)));
        in_order   = (n1 == l1 + W1'(1)) || (n1 + r1 == l1 + W1'(1));
        fwd_gap    = (n1 < l1 + half1) && (n1 > l1);
        wrap_gap   = (n1 + half1 < l1) && (n1 + r1 >= l1);
    end

    // cell commands
    always_comb
    begin
        ctl      = '0;
        load_pos = '0;
        unique case (state_reg)
            S_SEARCH:
            begin
                ctl.shift = 1'b1;
                if (!head_match)
                begin
                    ctl.load = 1'b1;
                    ctl.val  = head;
                    load_pos = IW'(count_reg - CW'(1));
                end
            end
            S_ALARM:
            begin
                ctl.shift = alarm_hit;
            end
            S_APPEND:
            begin
                if (run_left && !list_full)
                begin
                    ctl.load = 1'b1;
                    ctl.val  = lo_reg[SEQ_W-1:0];
                    load_pos = IW'(count_reg);
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (out_range || first_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_ALARM;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (scan_reg == CW'(1))
                begin
                    state_next = (found_reg || head_match) ? S_IDLE : S_ALARM;
                end
            end
            S_ALARM:
            begin
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                state_next = (!in_order && (fwd_gap || wrap_gap)) ? S_APPEND : S_IDLE;
            end
            S_APPEND:
            begin
                if ((run_left && list_full) || (!run_left && !wrap_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            range_reg <= SEQ_W'(10000);
            check_reg <= CHK_W'(16);
            last_reg  <= '0;
            first_reg <= 1'b1;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg != S_IDLE) && (state_next == S_IDLE);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SEQ_RANGE:   range_reg <= cfg_wdata & SEQ_MASK;
                    REG_CHECK_DEPTH: check_reg <= cfg_wdata[CHK_W-1:0];
                    default:         range_reg <= range_reg;
                endcase
            end
            unique case (state_reg)
                S_PRE:
                begin
                    if (!out_range && first_reg)
                    begin
                        last_reg  <= n_reg;
                        first_reg <= 1'b0;
                    end
                end
                S_SEARCH:
                begin
                    if (head_match)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_ALARM:
                begin
                    if (alarm_hit)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_CLASS:
                begin
                    last_reg <= n_reg;
                end
                S_APPEND:
                begin
                    if (run_left && !list_full)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // per-item working and result registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_reg       <= seq_number & SEQ_MASK;
                    status_reg  <= ST_OUT_OF_RANGE;
                    prev_reg    <= '0;
                    added_reg   <= '0;
                    alarm_v_reg <= 1'b0;
                    alarm_s_reg <= '0;
                    over_reg    <= 1'b0;
                end
            end
            S_PRE:
            begin
                scan_reg  <= count_reg;
                found_reg <= 1'b0;
                if (!out_range && first_reg)
                begin
                    status_reg <= ST_FIRST;
                end
            end
            S_SEARCH:
            begin
                scan_reg <= scan_reg - CW'(1);
                if (head_match)
                begin
                    found_reg  <= 1'b1;
                    status_reg <= ST_RECOVERED;
                end
            end
            S_ALARM:
            begin
                if (alarm_hit)
                begin
                    alarm_v_reg <= 1'b1;
                    alarm_s_reg <= head;
                end
            end
            S_CLASS:
            begin
                lo_reg <= l1 + W1'(1);
                if (in_order)
                begin
                    status_reg <= ST_IN_ORDER;
                end
                else
                begin
                    prev_reg <= last_reg;
                    if (fwd_gap)
                    begin
                        status_reg <= ST_GAP;
                        hi_reg     <= n1;
                        wrap_reg   <= 1'b0;
                    end
                    else if (wrap_gap)
                    begin
                        status_reg <= ST_GAP;
                        hi_reg     <= r1;
                        wrap_reg   <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_BACKWARD;
                    end
                end
            end
            S_APPEND:
            begin
                if (run_left)
                begin
                    if (list_full)
                    begin
                        over_reg <= 1'b1;
                    end
                    else
                    begin
                        lo_reg    <= lo_reg + W1'(1);
                        added_reg <= added_reg + SEQ_W'(1);
                    end
                end
                else if (wrap_reg)
                begin
                    wrap_reg <= 1'b0;
                    lo_reg   <= '0;
                    hi_reg   <= n1;
                end
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign previous_seq  = prev_reg;
    assign gap_added     = added_reg;
    assign alarm_valid   = alarm_v_reg;
    assign alarm_seq     = alarm_s_reg;
    assign list_overflow = over_reg;

    // list never grows past its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LOST_DEPTH))
        else $error("list count beyond capacity");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held more than one cycle");

    // only gap results carry appended numbers or overflow
    a_gap_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((gap_added != '0) || list_overflow) |-> status == ST_GAP)
        else $error("appended numbers on a non-gap result");

    // the list only changes while an item is at work
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> $stable(count_reg))
        else $error("list count moved while idle");

endmodule
